@@ rtl/mmcp_pkg.sv @@
// Shared constants, lane types and the divider step for the MIT-mode command packer.
// No dependencies; imported by mit_mode_command_packer.
`timescale 1ns / 1ps

package mmcp_pkg;

	// Lanes, one per command value
	localparam int NUM_LANES = 5;
	localparam int LANE_POS  = 0;
	localparam int LANE_VEL  = 1;
	localparam int LANE_KP   = 2;
	localparam int LANE_KD   = 3;
	localparam int LANE_TRQ  = 4;

	// Quotient bits computed per lane; 12-bit codes take the top 12
	localparam int POS_BITS   = 16;
	localparam int OTHER_BITS = 12;
	localparam int DIV_STEPS  = POS_BITS;

	// Frame ID packet type, bits 11..8
	localparam logic [3:0] MIT_PACKET_TYPE = 4'h8;

	// Fixed gain limits, Q16.16
	localparam logic signed [31:0] KP_MIN = 32'sd0;
	localparam logic signed [31:0] KP_MAX = 32'sd32768000;
	localparam logic signed [31:0] KD_MIN = 32'sd0;
	localparam logic signed [31:0] KD_MAX = 32'sd327680;

	// Configuration register indexes
	localparam int CFG_IDX_W = 3;
	localparam int NUM_REGS  = 6;
	localparam logic [CFG_IDX_W-1:0] REG_POS_MIN = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_POS_MAX = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_VEL_MIN = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_VEL_MAX = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_TRQ_MIN = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_TRQ_MAX = 3'd5;

	// Register reset values
	localparam logic signed [31:0] POS_MIN_RST = -32'sd819200;
	localparam logic signed [31:0] POS_MAX_RST = 32'sd819200;
	localparam logic signed [31:0] VEL_MIN_RST = -32'sd3276800;
	localparam logic signed [31:0] VEL_MAX_RST = 32'sd3276800;
	localparam logic signed [31:0] TRQ_MIN_RST = -32'sd1179648;
	localparam logic signed [31:0] TRQ_MAX_RST = 32'sd1179648;

	// Clamped value with its limits
	typedef struct packed {
		logic signed [31:0] xc;
		logic signed [31:0] lo;
		logic signed [31:0] hi;
		logic               zero;  // max <= min, code forced to 0
		logic               sat;   // value at or above max, top code
	} clamp_lane_t;

	// Restoring divider state for one lane
	typedef struct packed {
		logic [31:0]         rem;
		logic [31:0]         span;
		logic [POS_BITS-1:0] quo;
		logic                zero;
		logic                sat;
	} div_lane_t;

	// One restoring division step: shift, compare, conditional subtract
	function automatic div_lane_t div_step(input div_lane_t d);
		logic [32:0] r2;
		logic        ge;
		div_lane_t   o;
		r2 = {d.rem, 1'b0};
		ge = (r2 >= {1'b0, d.span});
		o = d;
		o.rem = ge ? 32'(r2 - {1'b0, d.span}) : r2[31:0];
		o.quo = {d.quo[POS_BITS-2:0], ge};
		return o;
	endfunction

endpackage

@@ rtl/mit_mode_command_packer.sv @@
// MIT-mode command packer: clamps, scales and packs one motor command into a CAN frame.
// Depends on mmcp_pkg (lane types, limits, divider step).
//
// Usage:
//  - Command channel (in_valid/in_ready): node_id and five signed Q16.16 values.
//  - Frame channel (out_valid/out_ready): frame_id = 0x800 | node_id and the
//    8 payload bytes as payload_high (bytes 0..3) and payload_low (bytes 4..7).
//  - Limit registers (cfg_valid/cfg_ready, cfg_index, cfg_data): position,
//    velocity and torque min/max, indexes 0..5; other indexes are dropped.
//    cfg_ready is always high; write only while no command is in flight.
//  - Pipeline: 19 register stages: one clamp stage, one offset/span stage,
//    16 restoring divider stages (one quotient bit each, a 33-bit compare
//    and subtract per stage) and the packing/output register.
//  - Throughput: one command per cycle while no frame is stalled, every lane has its own divider pipe.
//  - Stall: when out_ready is low with a frame waiting, the whole pipe holds
//    and in_ready drops; nothing is lost or repeated.
//  - Reset: clears all valid bits and loads the default limits.
`timescale 1ns / 1ps

module mit_mode_command_packer (
	input  logic                              clk,
	input  logic                              arst_n,
	// limit register write
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [mmcp_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [31:0]                       cfg_data,
	// command items
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [7:0]                        node_id,
	input  logic signed [31:0]                target_position,
	input  logic signed [31:0]                target_velocity,
	input  logic signed [31:0]                stiffness_gain,
	input  logic signed [31:0]                damping_gain,
	input  logic signed [31:0]                feedforward_torque,
	// frame items
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [11:0]                       frame_id,
	output logic [31:0]                       payload_high,
	output logic [31:0]                       payload_low
);

	import mmcp_pkg::*;

	// Limit registers
	logic signed [31:0] lim_q [NUM_REGS];

	// Pipeline registers
	logic        vld_s1, vld_s2, vld_s19;
	logic [7:0]  id_s1, id_s2;
	clamp_lane_t lane_s1 [NUM_LANES];
	div_lane_t   lane_s2 [NUM_LANES];
	// divider stages: index k holds stage s(k+3)
	logic [DIV_STEPS-1:0] dv_vld_s;
	logic [7:0]           dv_id_s   [DIV_STEPS];
	div_lane_t            dv_lane_s [DIV_STEPS][NUM_LANES];
	logic [11:0]          frame_id_s19;
	logic [31:0]          ph_s19, pl_s19;

	logic               adv;
	logic signed [31:0] x_in [NUM_LANES];
	logic signed [31:0] lo_in [NUM_LANES];
	logic signed [31:0] hi_in [NUM_LANES];
	clamp_lane_t        clamp_c [NUM_LANES];
	div_lane_t          sub_c [NUM_LANES];
	div_lane_t          fin [NUM_LANES];
	logic [POS_BITS-1:0]   pos_code;
	logic [OTHER_BITS-1:0] vel_code, kp_code, kd_code, trq_code;

	// Global advance: the pipe moves unless a finished frame is stuck
	assign adv       = !vld_s19 || out_ready;
	assign in_ready  = adv;
	assign cfg_ready = 1'b1;

	// Limit register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lim_q[REG_POS_MIN] <= POS_MIN_RST;
			lim_q[REG_POS_MAX] <= POS_MAX_RST;
			lim_q[REG_VEL_MIN] <= VEL_MIN_RST;
			lim_q[REG_VEL_MAX] <= VEL_MAX_RST;
			lim_q[REG_TRQ_MIN] <= TRQ_MIN_RST;
			lim_q[REG_TRQ_MAX] <= TRQ_MAX_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_POS_MIN: lim_q[REG_POS_MIN] <= cfg_data;
				REG_POS_MAX: lim_q[REG_POS_MAX] <= cfg_data;
				REG_VEL_MIN: lim_q[REG_VEL_MIN] <= cfg_data;
				REG_VEL_MAX: lim_q[REG_VEL_MAX] <= cfg_data;
				REG_TRQ_MIN: lim_q[REG_TRQ_MIN] <= cfg_data;
				REG_TRQ_MAX: lim_q[REG_TRQ_MAX] <= cfg_data;
				default: ;
			endcase
		end
	end

	// Stage 1 inputs: value and limits per lane
	always_comb begin
		x_in[LANE_POS]  = target_position;
		x_in[LANE_VEL]  = target_velocity;
		x_in[LANE_KP]   = stiffness_gain;
		x_in[LANE_KD]   = damping_gain;
		x_in[LANE_TRQ]  = feedforward_torque;
		lo_in[LANE_POS] = lim_q[REG_POS_MIN];
		hi_in[LANE_POS] = lim_q[REG_POS_MAX];
		lo_in[LANE_VEL] = lim_q[REG_VEL_MIN];
		hi_in[LANE_VEL] = lim_q[REG_VEL_MAX];
		lo_in[LANE_KP]  = KP_MIN;
		hi_in[LANE_KP]  = KP_MAX;
		lo_in[LANE_KD]  = KD_MIN;
		hi_in[LANE_KD]  = KD_MAX;
		lo_in[LANE_TRQ] = lim_q[REG_TRQ_MIN];
		hi_in[LANE_TRQ] = lim_q[REG_TRQ_MAX];
	end

	// Clamp to [min, max], flag empty range and saturation
	always_comb begin
		for (int l = 0; l < NUM_LANES; l++) begin
			clamp_c[l].lo   = lo_in[l];
			clamp_c[l].hi   = hi_in[l];
			clamp_c[l].zero = (hi_in[l] <= lo_in[l]);
			clamp_c[l].sat  = (x_in[l] >= hi_in[l]);
			if (x_in[l] < lo_in[l]) begin
				clamp_c[l].xc = lo_in[l];
			end else if (x_in[l] > hi_in[l]) begin
				clamp_c[l].xc = hi_in[l];
			end else begin
				clamp_c[l].xc = x_in[l];
			end
		end
	end

	// Offset and span; both fit 32 unsigned bits when the range is not empty
	always_comb begin
		for (int l = 0; l < NUM_LANES; l++) begin
			sub_c[l].rem  = 32'(lane_s1[l].xc - lane_s1[l].lo);
			sub_c[l].span = 32'(lane_s1[l].hi - lane_s1[l].lo);
			sub_c[l].quo  = '0;
			sub_c[l].zero = lane_s1[l].zero;
			sub_c[l].sat  = lane_s1[l].sat;
		end
	end

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1   <= 1'b0;
			vld_s2   <= 1'b0;
			dv_vld_s <= '0;
			vld_s19  <= 1'b0;
		end else if (adv) begin
			vld_s1   <= in_valid;
			vld_s2   <= vld_s1;
			dv_vld_s <= {dv_vld_s[DIV_STEPS-2:0], vld_s2};
			vld_s19  <= dv_vld_s[DIV_STEPS-1];
		end
	end

	// Front stages data
	always_ff @(posedge clk) begin
		if (adv) begin
			id_s1   <= node_id;
			lane_s1 <= clamp_c;
			id_s2   <= id_s1;
			lane_s2 <= sub_c;
		end
	end

	// Divider stages, one quotient bit per stage
	for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
		if (k == 0) begin : g_first
			always_ff @(posedge clk) begin
				if (adv) begin
					dv_id_s[k] <= id_s2;
					for (int l = 0; l < NUM_LANES; l++) begin
						dv_lane_s[k][l] <= div_step(lane_s2[l]);
					end
				end
			end
		end else begin : g_next
			always_ff @(posedge clk) begin
				if (adv) begin
					dv_id_s[k] <= dv_id_s[k-1];
					for (int l = 0; l < NUM_LANES; l++) begin
						dv_lane_s[k][l] <= div_step(dv_lane_s[k-1][l]);
					end
				end
			end
		end
	end

	// Code selection: empty range, saturation or quotient
	always_comb begin
		for (int l = 0; l < NUM_LANES; l++) begin
			fin[l] = dv_lane_s[DIV_STEPS-1][l];
		end
		pos_code = fin[LANE_POS].zero ? '0 :
			fin[LANE_POS].sat ? '1 : fin[LANE_POS].quo;
		vel_code = fin[LANE_VEL].zero ? '0 :
			fin[LANE_VEL].sat ? '1 : fin[LANE_VEL].quo[POS_BITS-1 -: OTHER_BITS];
		kp_code  = fin[LANE_KP].zero ? '0 :
			fin[LANE_KP].sat ? '1 : fin[LANE_KP].quo[POS_BITS-1 -: OTHER_BITS];
		kd_code  = fin[LANE_KD].zero ? '0 :
			fin[LANE_KD].sat ? '1 : fin[LANE_KD].quo[POS_BITS-1 -: OTHER_BITS];
		trq_code = fin[LANE_TRQ].zero ? '0 :
			fin[LANE_TRQ].sat ? '1 : fin[LANE_TRQ].quo[POS_BITS-1 -: OTHER_BITS];
	end

	// Frame packing and output register
	always_ff @(posedge clk) begin
		if (adv) begin
			frame_id_s19 <= {MIT_PACKET_TYPE, dv_id_s[DIV_STEPS-1]};
			ph_s19       <= {kp_code, kd_code, pos_code[15:8]};
			pl_s19       <= {pos_code[7:0], vel_code, trq_code};
		end
	end

	assign out_valid    = vld_s19;
	assign frame_id     = frame_id_s19;
	assign payload_high = ph_s19;
	assign payload_low  = pl_s19;

	// Divider remainder stays below the span on live, non-special lanes
	for (genvar l = 0; l < NUM_LANES; l++) begin : g_chk
		a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
			(dv_vld_s[DIV_STEPS-1] && !fin[l].zero && !fin[l].sat)
			|-> (fin[l].rem < fin[l].span))
			else $error("divider remainder out of range on lane %0d", l);
	end

	// Empty position range gives a zero position code in the frame
	a_pos_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && dv_vld_s[DIV_STEPS-1] && fin[LANE_POS].zero)
		|=> (payload_high[7:0] == 8'h00 && payload_low[31:24] == 8'h00))
		else $error("empty position range did not give code zero");

	// Saturated torque lane gives the top torque code
	a_trq_sat: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && dv_vld_s[DIV_STEPS-1] && !fin[LANE_TRQ].zero && fin[LANE_TRQ].sat)
		|=> (payload_low[11:0] == 12'hFFF))
		else $error("saturated torque did not give top code");

	// A held frame freezes the pipe: no input accepted while stalled
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |-> !in_ready)
		else $error("input accepted while output stalled");

endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench for mit_mode_command_packer: clamping, scaling and frame packing.
// Depends on mmcp_pkg and the packer RTL; predicts each frame and checks it against the block.
`timescale 1ns / 1ps

module tb_top;
	import mmcp_pkg::*;

	localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;
	localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
	// indexes past the register file, writes there are dropped
	localparam logic [CFG_IDX_W-1:0] REG_NONE_LO = CFG_IDX_W'(NUM_REGS);
	localparam logic [CFG_IDX_W-1:0] REG_NONE_HI = '1;
	localparam int WATCHDOG_CYCLES = 200000;
	localparam int DRAIN_CYCLES    = 40;

	typedef struct {
		logic [7:0]         node_id;
		logic signed [31:0] pos;
		logic signed [31:0] vel;
		logic signed [31:0] kp;
		logic signed [31:0] kd;
		logic signed [31:0] trq;
	} cmd_t;

	typedef struct {
		logic [11:0] frame_id;
		logic [31:0] payload_high;
		logic [31:0] payload_low;
	} frame_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [7:0] node_id = '0;
	logic signed [31:0] target_position = '0;
	logic signed [31:0] target_velocity = '0;
	logic signed [31:0] stiffness_gain = '0;
	logic signed [31:0] damping_gain = '0;
	logic signed [31:0] feedforward_torque = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [11:0] frame_id;
	logic [31:0] payload_high;
	logic [31:0] payload_low;

	// predictor copy of the limit registers
	logic signed [31:0] limit_reg [NUM_REGS];
	frame_t pending_frames [$];
	int err_count = 0;
	int cycle_count = 0;
	int send_gap_pct = 0;
	int sink_stall_pct = 0;
	int sink_hold_req = 0;

	mit_mode_command_packer u_top (
		.clk                (clk),
		.arst_n             (arst_n),
		.cfg_valid          (cfg_valid),
		.cfg_ready          (cfg_ready),
		.cfg_index          (cfg_index),
		.cfg_data           (cfg_data),
		.in_valid           (in_valid),
		.in_ready           (in_ready),
		.node_id            (node_id),
		.target_position    (target_position),
		.target_velocity    (target_velocity),
		.stiffness_gain     (stiffness_gain),
		.damping_gain       (damping_gain),
		.feedforward_torque (feedforward_torque),
		.out_valid          (out_valid),
		.out_ready          (out_ready),
		.frame_id           (frame_id),
		.payload_high       (payload_high),
		.payload_low        (payload_low)
	);

	always #4 clk = ~clk;

	// Linear scale of a clamped value to an unsigned code, saturated to the top code
	function automatic logic [15:0] scale_code(logic signed [31:0] x, logic signed [31:0] lo,
			logic signed [31:0] hi, int bits);
		longint xs;
		longint span;
		longint off;
		longint q;
		longint top;
		top = (longint'(1) << bits) - 1;
		// empty or inverted limits give code zero
		if (hi <= lo)
			return '0;
		xs = x;
		if (xs < lo)
			xs = lo;
		if (xs > hi)
			xs = hi;
		span = longint'(hi) - longint'(lo);
		off = xs - longint'(lo);
		q = (off << bits) / span;
		if (q > top)
			q = top;
		return q[15:0];
	endfunction

	function automatic frame_t pack_command(cmd_t c);
		logic [15:0] p;
		logic [11:0] v;
		logic [11:0] kp;
		logic [11:0] kd;
		logic [11:0] t;
		frame_t f;
		p  = scale_code(c.pos, limit_reg[REG_POS_MIN], limit_reg[REG_POS_MAX], POS_BITS);
		v  = 12'(scale_code(c.vel, limit_reg[REG_VEL_MIN], limit_reg[REG_VEL_MAX], OTHER_BITS));
		kp = 12'(scale_code(c.kp, KP_MIN, KP_MAX, OTHER_BITS));
		kd = 12'(scale_code(c.kd, KD_MIN, KD_MAX, OTHER_BITS));
		t  = 12'(scale_code(c.trq, limit_reg[REG_TRQ_MIN], limit_reg[REG_TRQ_MAX], OTHER_BITS));
		f.frame_id     = {MIT_PACKET_TYPE, c.node_id};
		f.payload_high = {kp, kd, p[15:8]};
		f.payload_low  = {p[7:0], v, t};
		return f;
	endfunction

	function automatic cmd_t make_cmd(logic [7:0] id, logic signed [31:0] p,
			logic signed [31:0] v, logic signed [31:0] kp, logic signed [31:0] kd,
			logic signed [31:0] t);
		cmd_t c;
		c.node_id = id;
		c.pos = p;
		c.vel = v;
		c.kp  = kp;
		c.kd  = kd;
		c.trq = t;
		return c;
	endfunction

	// Mostly values inside the limits, some right at the edges, the rest anywhere
	function automatic logic signed [31:0] pick_value(logic signed [31:0] lo,
			logic signed [31:0] hi);
		longint span;
		logic [63:0] r;
		int sel;
		sel = $urandom_range(0, 99);
		span = longint'(hi) - longint'(lo);
		if (sel < 25 || span <= 0)
			return $urandom;
		if (sel < 40) begin
			case ($urandom_range(0, 5))
				0: return lo;
				1: return hi;
				2: return lo - 1;
				3: return hi + 1;
				4: return lo + 1;
				default: return hi - 1;
			endcase
		end
		r = {$urandom, $urandom};
		return 32'(longint'(lo) + longint'(r % 64'(span + 1)));
	endfunction

	function automatic cmd_t random_command();
		cmd_t c;
		c.node_id = 8'($urandom);
		c.pos = pick_value(limit_reg[REG_POS_MIN], limit_reg[REG_POS_MAX]);
		c.vel = pick_value(limit_reg[REG_VEL_MIN], limit_reg[REG_VEL_MAX]);
		c.kp  = pick_value(KP_MIN, KP_MAX);
		c.kd  = pick_value(KD_MIN, KD_MAX);
		c.trq = pick_value(limit_reg[REG_TRQ_MIN], limit_reg[REG_TRQ_MAX]);
		return c;
	endfunction

	// Offer one command item; valid stays high after acceptance until the next gap or drain
	task automatic send_command(cmd_t c);
		if ($urandom_range(0, 99) < send_gap_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		in_valid           <= 1'b1;
		node_id            <= c.node_id;
		target_position    <= c.pos;
		target_velocity    <= c.vel;
		stiffness_gain     <= c.kp;
		damping_gain       <= c.kd;
		feedforward_torque <= c.trq;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		pending_frames.push_back(pack_command(c));
	endtask

	// Stop offering and wait until every predicted frame has come out
	task automatic drain_frames();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_frames.size() != 0)
			@(posedge clk);
	endtask

	// Limit register write; only called with the pipe empty
	task automatic write_limit(logic [CFG_IDX_W-1:0] idx, logic signed [31:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		if (idx < NUM_REGS)
			limit_reg[idx] = val;
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// Random limit pair: full range, inverted or empty, narrow, or ordered random
	task automatic random_span(output logic signed [31:0] lo, output logic signed [31:0] hi);
		logic signed [31:0] a;
		logic signed [31:0] b;
		int sel;
		sel = $urandom_range(0, 99);
		a = $urandom;
		b = $urandom;
		if (sel < 10) begin
			lo = S32_MIN;
			hi = S32_MAX;
		end else if (sel < 20) begin
			lo = a;
			hi = a - $urandom_range(0, 1000);
		end else if (sel < 40) begin
			lo = a;
			hi = a + $urandom_range(1, 4096);
		end else begin
			lo = (a < b) ? a : b;
			hi = (a < b) ? b : a;
		end
	endtask

	task automatic randomize_limits();
		logic signed [31:0] lo;
		logic signed [31:0] hi;
		random_span(lo, hi);
		write_limit(REG_POS_MIN, lo);
		write_limit(REG_POS_MAX, hi);
		random_span(lo, hi);
		write_limit(REG_VEL_MIN, lo);
		write_limit(REG_VEL_MAX, hi);
		random_span(lo, hi);
		write_limit(REG_TRQ_MIN, lo);
		write_limit(REG_TRQ_MAX, hi);
	endtask

	// Values at, just inside and beyond the default limits
	task automatic test_limit_edges();
		send_command(make_cmd(8'h00, limit_reg[REG_POS_MIN], limit_reg[REG_VEL_MIN],
			KP_MIN, KD_MIN, limit_reg[REG_TRQ_MIN]));
		send_command(make_cmd(8'hFF, limit_reg[REG_POS_MAX], limit_reg[REG_VEL_MAX],
			KP_MAX, KD_MAX, limit_reg[REG_TRQ_MAX]));
		send_command(make_cmd(8'h5A, S32_MAX, S32_MAX, S32_MAX, S32_MAX, S32_MAX));
		send_command(make_cmd(8'hA5, S32_MIN, S32_MIN, S32_MIN, S32_MIN, S32_MIN));
		send_command(make_cmd(8'h01, 0, 0, 0, 0, 0));
		send_command(make_cmd(8'h80, limit_reg[REG_POS_MAX] - 1, limit_reg[REG_VEL_MAX] - 1,
			KP_MAX - 1, KD_MAX - 1, limit_reg[REG_TRQ_MAX] - 1));
		send_command(make_cmd(8'h7F, limit_reg[REG_POS_MIN] + 1, limit_reg[REG_VEL_MIN] + 1,
			KP_MIN + 1, KD_MIN + 1, limit_reg[REG_TRQ_MIN] + 1));
		send_command(make_cmd(8'h3C, -1, -1, 1, 1, -1));
		drain_frames();
	endtask

	// Writes past the last register must leave the limits alone
	task automatic test_ignored_index();
		write_limit(REG_NONE_LO, $urandom);
		write_limit(REG_NONE_HI, $urandom);
		send_command(make_cmd(8'h12, limit_reg[REG_POS_MAX], 32'sd65536, 32'sd1000000,
			32'sd100000, limit_reg[REG_TRQ_MIN]));
		send_command(random_command());
		drain_frames();
	endtask

	// Widest possible limits: span of 2^32 - 1
	task automatic test_full_range();
		write_limit(REG_POS_MIN, S32_MIN);
		write_limit(REG_POS_MAX, S32_MAX);
		write_limit(REG_VEL_MIN, S32_MIN);
		write_limit(REG_VEL_MAX, S32_MAX);
		write_limit(REG_TRQ_MIN, S32_MIN);
		write_limit(REG_TRQ_MAX, S32_MAX);
		send_command(make_cmd(8'h20, S32_MIN, S32_MIN, S32_MIN, S32_MIN, S32_MIN));
		send_command(make_cmd(8'h21, S32_MAX, S32_MAX, S32_MAX, S32_MAX, S32_MAX));
		send_command(make_cmd(8'h22, 0, 0, 0, 0, 0));
		send_command(make_cmd(8'h23, -1, -1, -1, -1, -1));
		drain_frames();
	endtask

	// Empty and inverted limits force code zero
	task automatic test_empty_limits();
		write_limit(REG_POS_MIN, 32'sd12345);
		write_limit(REG_POS_MAX, 32'sd12345);
		write_limit(REG_VEL_MIN, S32_MAX);
		write_limit(REG_VEL_MAX, S32_MIN);
		write_limit(REG_TRQ_MIN, 32'sd0);
		write_limit(REG_TRQ_MAX, -32'sd1);
		send_command(make_cmd(8'h40, 32'sd12345, S32_MAX, KP_MAX, KD_MAX, 32'sd0));
		send_command(make_cmd(8'h41, S32_MAX, S32_MIN, 32'sd4096, 32'sd4096, -32'sd1));
		send_command(make_cmd(8'h42, S32_MIN, 0, S32_MIN, S32_MAX, S32_MAX));
		drain_frames();
	endtask

	// Several random limit settings, random commands, idling on both sides
	task automatic test_random_phases();
		for (int ph = 0; ph < 5; ph++) begin
			randomize_limits();
			send_gap_pct   = (ph == 2) ? 0 : 25;
			sink_stall_pct = (ph == 3) ? 0 : 20;
			repeat (110)
				send_command(random_command());
			drain_frames();
		end
	endtask

	// Long receiver hold-off fills the pipe; then sender pauses for a full drain
	task automatic test_backpressure();
		send_gap_pct   = 0;
		sink_stall_pct = 0;
		sink_hold_req  = 100;
		repeat (60)
			send_command(random_command());
		drain_frames();
		repeat (20)
			send_command(random_command());
		drain_frames();
	endtask

	// Back-to-back commands with no idling at all
	task automatic test_streaming();
		randomize_limits();
		send_gap_pct   = 0;
		sink_stall_pct = 0;
		repeat (150)
			send_command(random_command());
		drain_frames();
	endtask

	task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			err_count++;
			$display("%0t ns: %s mismatch, expected %h, got %h", $time, name, want, got);
		end
	endtask

	// Frame receiver: random stall bursts, or a long hold when asked
	initial begin : frame_sink
		int stall_left;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (sink_hold_req > 0) begin
				stall_left = sink_hold_req;
				sink_hold_req = 0;
			end else if (stall_left == 0 && $urandom_range(0, 99) < sink_stall_pct) begin
				stall_left = $urandom_range(1, 7);
			end
			if (stall_left > 0) begin
				out_ready <= 1'b0;
				stall_left--;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Compare each accepted frame with the oldest prediction
	always @(posedge clk) begin
		frame_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_frames.size() == 0) begin
				err_count++;
				$display("%0t ns: frame with none expected, got id %h payload %h %h",
					$time, frame_id, payload_high, payload_low);
			end else begin
				want = pending_frames.pop_front();
				check_field("frame_id", 32'(want.frame_id), 32'(frame_id));
				check_field("payload_high", want.payload_high, payload_high);
				check_field("payload_low", want.payload_low, payload_low);
			end
		end
	end

	// Watchdog
	initial begin : watchdog
		while (cycle_count < WATCHDOG_CYCLES) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("TB_ERROR");
		$finish;
	end

	initial begin : main
		limit_reg[REG_POS_MIN] = POS_MIN_RST;
		limit_reg[REG_POS_MAX] = POS_MAX_RST;
		limit_reg[REG_VEL_MIN] = VEL_MIN_RST;
		limit_reg[REG_VEL_MAX] = VEL_MAX_RST;
		limit_reg[REG_TRQ_MIN] = TRQ_MIN_RST;
		limit_reg[REG_TRQ_MAX] = TRQ_MAX_RST;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		sink_stall_pct = 20;
		send_gap_pct   = 25;
		test_limit_edges();
		test_ignored_index();
		test_full_range();
		test_empty_limits();
		test_random_phases();
		test_backpressure();
		test_streaming();

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (err_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
